// File: rtl/core/qcse_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qcse_pkg
// Shared widths, register indexes and status types of the quadrature
// count and speed estimate block.
// ----------------------------------------------------------------------------
package qcse_pkg;

	// Width of the stored edge and estimate timestamps.
	localparam int TIME_WIDTH = 32;

	localparam int STAMP_W    = 32;
	localparam int COUNT_W    = 32;
	localparam int CONV_W     = 32;
	localparam int SPEED_W    = 32;
	localparam int PROD_W     = COUNT_W + CONV_W;
	localparam int QUO_W      = SPEED_W;
	localparam int HIGH_W     = PROD_W - QUO_W;
	localparam int REM_W      = ((TIME_WIDTH > HIGH_W) ? TIME_WIDTH : HIGH_W) + 1;
	localparam int CNT_W      = $clog2(QUO_W);

	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_CONVERSION = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_INVERT     = CFG_IDX_W'(1);

	localparam logic [CONV_W-1:0] CONVERSION_RESET = CONV_W'(150000);

	localparam logic OP_EDGE     = 1'b0;
	localparam logic OP_ESTIMATE = 1'b1;

	localparam logic [SPEED_W-1:0] SPEED_MAX = {1'b0, {(SPEED_W-1){1'b1}}};
	localparam logic [SPEED_W-1:0] SPEED_MIN = {1'b1, {(SPEED_W-1){1'b0}}};

	typedef struct packed {
		logic busy;
		logic ovf;
	} qcse_div_stat_t;

endpackage

// File: rtl/core/qcse_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qcse_in_if
// Request channel: encoder edge events and speed estimate requests.
// ----------------------------------------------------------------------------
interface qcse_in_if;
	import qcse_pkg::*;

	logic               valid;
	logic               ready;
	logic               op;
	logic               from_channel_a;
	logic               a_level;
	logic               b_level;
	logic [STAMP_W-1:0] time_us;

	modport source (output valid, op, from_channel_a, a_level, b_level, time_us,
		input ready);
	modport sink (input valid, op, from_channel_a, a_level, b_level, time_us,
		output ready);
endinterface

// File: rtl/core/qcse_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qcse_out_if
// Result channel: one signed speed value per estimate request.
// ----------------------------------------------------------------------------
interface qcse_out_if;
	import qcse_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [SPEED_W-1:0] speed;

	modport source (output valid, speed, input ready);
	modport sink (input valid, speed, output ready);
endinterface

// File: rtl/core/qcse_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qcse_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface qcse_cfg_if;
	import qcse_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/core/qcse_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qcse_divider
// Restoring divider, one quotient bit per cycle on a shared subtractor.
// A first pass flags quotients that do not fit in QUO_W bits.
// ----------------------------------------------------------------------------
module qcse_divider (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [qcse_pkg::PROD_W-1:0]      dividend,
	input  logic [qcse_pkg::TIME_WIDTH-1:0]  divisor,
	output qcse_pkg::qcse_div_stat_t         stat,
	output logic [qcse_pkg::QUO_W-1:0]       quotient
);
	import qcse_pkg::*;

	localparam logic [1:0] D_IDLE  = 2'd0;
	localparam logic [1:0] D_CHECK = 2'd1;
	localparam logic [1:0] D_ITER  = 2'd2;

	logic [1:0]            st_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  ovf_q;
	logic [REM_W-1:0]      rem_q;
	logic [QUO_W-1:0]      quo_q;
	logic [TIME_WIDTH-1:0] div_q;

	logic [REM_W-1:0]      shifted;
	logic [REM_W-1:0]      opa;
	logic [REM_W:0]        diff;
	logic                  ge;

	// Shared subtractor: compare in the check pass, trial subtract otherwise.
	assign shifted = {rem_q[REM_W-2:0], quo_q[QUO_W-1]};
	assign opa     = (st_q == D_CHECK) ? rem_q : shifted;
	assign diff    = {1'b0, opa} - {1'b0, REM_W'(div_q)};
	assign ge      = ~diff[REM_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= D_IDLE;
			cnt_q <= '0;
			ovf_q <= 1'b0;
		end else begin
			unique case (st_q)
				D_IDLE: begin
					if (start) begin
						st_q  <= D_CHECK;
						cnt_q <= '0;
						ovf_q <= 1'b0;
					end
				end
				D_CHECK: begin
					if (ge) begin
						ovf_q <= 1'b1;
						st_q  <= D_IDLE;
					end else begin
						st_q <= D_ITER;
					end
				end
				D_ITER: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(QUO_W - 1)) begin
						st_q <= D_IDLE;
					end
				end
				default: begin
					st_q <= D_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == D_IDLE && start) begin
			rem_q <= REM_W'(dividend[PROD_W-1:QUO_W]);
			quo_q <= dividend[QUO_W-1:0];
			div_q <= divisor;
		end else if (st_q == D_ITER) begin
			rem_q <= ge ? diff[REM_W-1:0] : shifted;
			quo_q <= {quo_q[QUO_W-2:0], ge};
		end
	end

	assign stat.busy = (st_q != D_IDLE);
	assign stat.ovf  = ovf_q;
	assign quotient  = quo_q;

endmodule

// File: rtl/core/quadrature_count_speed_estimate.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadrature_count_speed_estimate
// x4 quadrature tick counter with a raw speed estimate: ticks times
// conversion over the span between the last edge times seen at successive
// estimates, computed by an iterative divider.
// ----------------------------------------------------------------------------
//
//  channel    role     handshake     payload
//  ---------  -------  ------------  --------------------------------------
//  event_req  sink     valid/ready   op, from_channel_a, a_level, b_level,
//                                    time_us
//  speed_rsp  source   valid/ready   speed (signed 32)
//  cfg        sink     valid/ready   index, data (0 conversion, 1 invert)
//
//  An edge event is taken whenever ready is high. An estimate request latches
//  the tick magnitude as it is taken, then holds ready low until its result
//  is loaded: the 32x32 multiplier feeds the divider's input registers, then
//  one overflow check, 32 quotient steps on the divider's shared subtractor
//  and the load of the output register. A quotient that overflows, or a zero
//  span, skips the steps.
//  A finished speed waits in the output register; edge events are still
//  taken, and a further estimate runs its divide, then holds with ready low
//  until that register is free.
//  Reset clears the count, both timestamps and loads the register defaults.
//  Config writes are always ready.
// ----------------------------------------------------------------------------
module quadrature_count_speed_estimate (
	input  logic clk,
	input  logic arst_n,
	qcse_in_if.sink    event_req,
	qcse_out_if.source speed_rsp,
	qcse_cfg_if.sink   cfg
);
	import qcse_pkg::*;

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_START = 2'd1;
	localparam logic [1:0] S_DIV   = 2'd2;

	logic [1:0]            state_q;
	logic [COUNT_W-1:0]    tick_q;
	logic [TIME_WIDTH-1:0] last_edge_q;
	logic [TIME_WIDTH-1:0] last_est_q;
	logic [CONV_W-1:0]     conv_q;
	logic                  invert_q;

	logic [COUNT_W-1:0]    mag_q;
	logic                  neg_q;
	logic                  zero_q;
	logic [TIME_WIDTH-1:0] delta_q;

	logic                  out_valid_q;
	logic [SPEED_W-1:0]    speed_q;

	logic                  in_acc;
	logic                  est_acc;
	logic                  edge_acc;
	logic                  count_up;
	logic [TIME_WIDTH-1:0] delta;
	logic [PROD_W-1:0]     prod;
	logic                  div_start;
	qcse_div_stat_t        div_stat;
	logic [QUO_W-1:0]      quotient;
	logic                  sat_big;
	logic [SPEED_W-1:0]    signed_res;
	logic [SPEED_W-1:0]    final_res;
	logic                  out_free;
	logic                  finish;

	// Take requests only between estimates.
	assign event_req.ready = (state_q == S_IDLE);
	assign in_acc   = event_req.valid && event_req.ready;
	assign est_acc  = in_acc && (event_req.op == OP_ESTIMATE);
	assign edge_acc = in_acc && (event_req.op == OP_EDGE);

	// x4 rule: count up when the source channel differs from A == B.
	assign count_up = event_req.from_channel_a ^ (event_req.a_level == event_req.b_level);

	assign delta = last_edge_q - last_est_q;

	// Product feeds the divider's input register directly.
	assign prod      = PROD_W'(mag_q) * PROD_W'(conv_q);
	assign div_start = (state_q == S_START);

	qcse_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (prod),
		.divisor  (delta_q),
		.stat     (div_stat),
		.quotient (quotient)
	);

	// Saturate, apply sign, then force zero for a zero span or apply the optional direction flip.
	assign sat_big = div_stat.ovf || quotient[QUO_W-1];

	always_comb begin
		if (neg_q) begin
			signed_res = sat_big ? SPEED_MIN : (~quotient + 1'b1);
		end else begin
			signed_res = sat_big ? SPEED_MAX : quotient;
		end
		if (zero_q) begin
			final_res = '0;
		end else if (invert_q) begin
			final_res = (signed_res == SPEED_MIN) ? SPEED_MAX : (~signed_res + 1'b1);
		end else begin
			final_res = signed_res;
		end
	end

	assign out_free = !out_valid_q || speed_rsp.ready;
	assign finish   = (state_q == S_DIV) && !div_stat.busy && out_free;

	// Sequencer and architectural state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			tick_q      <= '0;
			last_edge_q <= '0;
			last_est_q  <= '0;
			conv_q      <= CONVERSION_RESET;
			invert_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				if (cfg.index == REG_CONVERSION) begin
					conv_q <= cfg.data[CONV_W-1:0];
				end else if (cfg.index == REG_INVERT) begin
					invert_q <= cfg.data[0];
				end
			end

			if (edge_acc) begin
				last_edge_q <= TIME_WIDTH'(event_req.time_us);
				tick_q      <= count_up ? (tick_q + 1'b1) : (tick_q - 1'b1);
			end else if (est_acc) begin
				last_est_q <= last_edge_q;
				tick_q     <= '0;
			end

			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (speed_rsp.ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (est_acc) begin
						state_q <= S_START;
					end
				end
				S_START: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (finish) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Capture the operands of an estimate; load the result register.
	always_ff @(posedge clk) begin
		if (est_acc) begin
			neg_q   <= tick_q[COUNT_W-1];
			mag_q   <= tick_q[COUNT_W-1] ? (~tick_q + 1'b1) : tick_q;
			delta_q <= delta;
			zero_q  <= (delta == '0);
		end
		if (finish) begin
			speed_q <= final_res;
		end
	end

	assign cfg.ready       = 1'b1;
	assign speed_rsp.valid = out_valid_q;
	assign speed_rsp.speed = speed_q;

	// Divider runs only while the sequencer waits on it.
	a_busy_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.busy |-> (state_q == S_DIV))
		else $error("divider busy outside the divide state");

	// An estimate request clears the count and starts the divider next cycle.
	a_est_clear: assert property (@(posedge clk) disable iff (!arst_n)
		est_acc |=> (tick_q == '0) && (state_q == S_START))
		else $error("estimate did not clear count or start divide");

	// A finished estimate never overwrites a result still waiting.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !speed_rsp.ready) |=> $stable(speed_q))
		else $error("pending speed overwritten");

	// Start a divide only from the start state, in the cycle after the request.
	a_start_follows: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> $past(est_acc))
		else $error("divider started without a request");

endmodule
